// File: sv/tcq_pkg.sv
// Shared types and constants for the tick clock timer queue.
// No dependencies.
`default_nettype none
package tcq_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = 5;
  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [29:0] RES_RESET  = 30'd10000000;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_SLEW   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_T_SLEW,
    ST_T_CLK,
    ST_S_RD,
    ST_S_CMP,
    ST_S_END,
    ST_S_FIRE,
    ST_P_ADD,
    ST_P_WR,
    ST_S_NEXT,
    ST_A_REL,
    ST_A_CHK,
    ST_A_WR,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// File: sv/tick_clock_timer_queue.sv
// Top level: time-of-day clock with timer slots, scanned by one compare unit.
// Depends on tcq_pkg and tcq_ram.
//
//  channel | dir | transfer when           | contents
//  in_     | in  | in_tvalid & in_tready  | tuser command, tdata arm/cancel/slew fields
//  out_    | out | out_tvalid & out_tready| tuser fired, tdata clock/slot/accepted, tlast
//  cfg_    | in  | cfg_wr_en              | tick resolution in ns
//
// Cancel and set correction go straight to the output wait; arm normalises, checks and
// writes the expiry first. Tick updates the clock, then per fired slot scans all slots through
// the expiry RAM read port and fires and reloads, plus one final empty scan when fewer than
// 16 slots fire; each result adds its output wait.
// in_tready is low from acceptance until the last result transfers.
// rst_n is synchronous; all slots are unset after reset.
`default_nettype none
module tick_clock_timer_queue #(
  parameter int SLOT_COUNT = tcq_pkg::SLOT_COUNT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // slot[3:0] when_seconds[35:4] when_nanoseconds[65:36] is_absolute[66]
  // is_periodic[67] period_seconds[99:68] period_nanoseconds[129:100]
  // slew_delta_ns[149:130] slew_ticks[181:150], zero pad
  input  wire logic [183:0] in_tdata,
  // command[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // clock_seconds_now[31:0] clock_nanoseconds_now[61:32] fired_slot[65:62]
  // accepted[66], zero pad
  output logic      [71:0]  out_tdata,
  // fired[0]
  output logic              out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [29:0]  cfg_wr_data
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  tcq_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [29:0] res_r, res_nxt;
  logic [31:0] clk_sec_r, clk_sec_nxt;
  logic [29:0] clk_ns_r, clk_ns_nxt;
  logic [19:0] slew_d_r, slew_d_nxt;
  logic [31:0] slew_rem_r, slew_rem_nxt;
  logic [31:0] acc_sec_r, acc_sec_nxt;
  logic [31:0] acc_ns_r, acc_ns_nxt;
  logic [61:0] exp_r, exp_nxt;
  logic [61:0] best_exp_r, best_exp_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [tcq_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [AW-1:0] pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [SLOT_COUNT-1:0] set_r, set_nxt, per_r, per_nxt, done_r, done_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic abs_r, abs_nxt, perf_r, perf_nxt;
  logic [31:0] psec_r, psec_nxt;
  logic [29:0] pns_r, pns_nxt;
  logic [31:0] o_sec_r, o_sec_nxt;
  logic [29:0] o_ns_r, o_ns_nxt;
  logic o_fired_r, o_fired_nxt, o_acc_r, o_acc_nxt, o_last_r, o_last_nxt;
  logic [3:0]  o_slot_r, o_slot_nxt;

  logic          in_xfer, out_xfer, in_range, slot_range, ns_big, elig, better, arm_ok;
  logic [3:0]    in_slot;
  logic [AW-1:0] in_addr, slot_addr;
  logic [61:0]   exp_rd, prd_rd, cur;
  logic          exp_we;
  logic [AW-1:0] exp_waddr;
  logic [61:0]   exp_wdata;

  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;
  assign in_slot    = in_tdata[3:0];
  assign in_addr    = AW'(in_slot);
  assign slot_addr  = AW'(slot_r);
  assign in_range   = {3'b000, in_slot} < 7'(SLOT_COUNT);
  assign slot_range = {3'b000, slot_r} < 7'(SLOT_COUNT);
  assign ns_big     = acc_ns_r >= tcq_pkg::NS_PER_SEC;
  assign cur        = {clk_sec_r, clk_ns_r};
  assign elig       = set_r[idx_r] && !done_r[idx_r] && (exp_rd <= cur);
  assign better     = !found_r || (exp_rd < best_exp_r);
  assign arm_ok     = slot_range && ({acc_sec_r, acc_ns_r[29:0]} > cur);

  assign exp_we    = (state_r == tcq_pkg::ST_P_WR) || (state_r == tcq_pkg::ST_A_WR);
  assign exp_waddr = (state_r == tcq_pkg::ST_P_WR) ? best_r : slot_addr;
  assign exp_wdata = (state_r == tcq_pkg::ST_P_WR) ? {acc_sec_r, acc_ns_r[29:0]} : exp_r;

  tcq_ram #(.W(62), .DEPTH(SLOT_COUNT), .AW(AW)) u_exp_ram (
    .clk  (clk),
    .we   (exp_we),
    .waddr(exp_waddr),
    .wdata(exp_wdata),
    .raddr(idx_r),
    .rdata(exp_rd)
  );

  tcq_ram #(.W(62), .DEPTH(SLOT_COUNT), .AW(AW)) u_prd_ram (
    .clk  (clk),
    .we   (state_r == tcq_pkg::ST_A_WR),
    .waddr(slot_addr),
    .wdata({acc_sec_r, acc_ns_r[29:0]}),
    .raddr(best_r),
    .rdata(prd_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      tcq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            tcq_pkg::CMD_TICK: state_nxt = tcq_pkg::ST_T_SLEW;
            tcq_pkg::CMD_ARM: begin
              state_nxt = tcq_pkg::ST_NORM;
              ret_nxt   = tcq_pkg::ST_A_REL;
            end
            default: begin
              state_nxt = tcq_pkg::ST_OUT;
              ret_nxt   = tcq_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tcq_pkg::ST_NORM: begin
        if (!ns_big) begin
          state_nxt = ret_r;
        end
      end
      tcq_pkg::ST_T_SLEW: begin
        state_nxt = tcq_pkg::ST_NORM;
        ret_nxt   = tcq_pkg::ST_T_CLK;
      end
      tcq_pkg::ST_T_CLK: state_nxt = tcq_pkg::ST_S_RD;
      tcq_pkg::ST_S_RD:  state_nxt = tcq_pkg::ST_S_CMP;
      tcq_pkg::ST_S_CMP: begin
        if (idx_r == AW'(SLOT_COUNT - 1)) begin
          state_nxt = tcq_pkg::ST_S_END;
        end else begin
          state_nxt = tcq_pkg::ST_S_RD;
        end
      end
      tcq_pkg::ST_S_END: begin
        if (!found_r) begin
          state_nxt = tcq_pkg::ST_OUT;
          ret_nxt   = tcq_pkg::ST_IDLE;
        end else if (pend_v_r) begin
          state_nxt = tcq_pkg::ST_OUT;
          ret_nxt   = tcq_pkg::ST_S_FIRE;
        end else begin
          state_nxt = tcq_pkg::ST_S_FIRE;
        end
      end
      tcq_pkg::ST_S_FIRE: begin
        if (per_r[best_r]) begin
          state_nxt = tcq_pkg::ST_P_ADD;
        end else begin
          state_nxt = tcq_pkg::ST_S_NEXT;
        end
      end
      tcq_pkg::ST_P_ADD: begin
        state_nxt = tcq_pkg::ST_NORM;
        ret_nxt   = tcq_pkg::ST_P_WR;
      end
      tcq_pkg::ST_P_WR: state_nxt = tcq_pkg::ST_S_NEXT;
      tcq_pkg::ST_S_NEXT: begin
        if (n_r == tcq_pkg::CNT_W'(tcq_pkg::MAX_RESULTS)) begin
          state_nxt = tcq_pkg::ST_OUT;
          ret_nxt   = tcq_pkg::ST_IDLE;
        end else begin
          state_nxt = tcq_pkg::ST_S_RD;
        end
      end
      tcq_pkg::ST_A_REL: begin
        state_nxt = abs_r ? tcq_pkg::ST_A_CHK : tcq_pkg::ST_NORM;
        ret_nxt   = tcq_pkg::ST_A_CHK;
      end
      tcq_pkg::ST_A_CHK: begin
        if (arm_ok) begin
          state_nxt = tcq_pkg::ST_NORM;
          ret_nxt   = tcq_pkg::ST_A_WR;
        end else begin
          state_nxt = tcq_pkg::ST_OUT;
          ret_nxt   = tcq_pkg::ST_IDLE;
        end
      end
      tcq_pkg::ST_A_WR: begin
        state_nxt = tcq_pkg::ST_OUT;
        ret_nxt   = tcq_pkg::ST_IDLE;
      end
      tcq_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = tcq_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    res_nxt      = cfg_wr_en ? cfg_wr_data : res_r;
    clk_sec_nxt  = clk_sec_r;
    clk_ns_nxt   = clk_ns_r;
    slew_d_nxt   = slew_d_r;
    slew_rem_nxt = slew_rem_r;
    acc_sec_nxt  = acc_sec_r;
    acc_ns_nxt   = acc_ns_r;
    exp_nxt      = exp_r;
    best_exp_nxt = best_exp_r;
    best_nxt     = best_r;
    found_nxt    = found_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    set_nxt      = set_r;
    per_nxt      = per_r;
    done_nxt     = done_r;
    slot_nxt     = slot_r;
    abs_nxt      = abs_r;
    perf_nxt     = perf_r;
    psec_nxt     = psec_r;
    pns_nxt      = pns_r;
    o_sec_nxt    = o_sec_r;
    o_ns_nxt     = o_ns_r;
    o_fired_nxt  = o_fired_r;
    o_slot_nxt   = o_slot_r;
    o_acc_nxt    = o_acc_r;
    o_last_nxt   = o_last_r;
    case (state_r)
      tcq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          slot_nxt    = in_slot;
          abs_nxt     = in_tdata[66];
          perf_nxt    = in_tdata[67];
          psec_nxt    = in_tdata[99:68];
          pns_nxt     = in_tdata[129:100];
          o_sec_nxt   = clk_sec_r;
          o_ns_nxt    = clk_ns_r;
          o_fired_nxt = 1'b0;
          o_slot_nxt  = 4'd0;
          o_acc_nxt   = 1'b0;
          o_last_nxt  = 1'b1;
          case (in_tuser)
            tcq_pkg::CMD_TICK: begin
              acc_sec_nxt = clk_sec_r;
              acc_ns_nxt  = {2'b00, clk_ns_r} + {2'b00, res_r};
            end
            tcq_pkg::CMD_ARM: begin
              acc_sec_nxt = in_tdata[35:4];
              acc_ns_nxt  = {2'b00, in_tdata[65:36]};
            end
            tcq_pkg::CMD_CANCEL: begin
              if (in_range && set_r[in_addr]) begin
                set_nxt[in_addr] = 1'b0;
                per_nxt[in_addr] = 1'b0;
                o_acc_nxt        = 1'b1;
              end
            end
            default: begin
              slew_d_nxt   = in_tdata[149:130];
              slew_rem_nxt = in_tdata[181:150];
            end
          endcase
        end
      end
      tcq_pkg::ST_NORM: begin
        if (ns_big) begin
          acc_ns_nxt  = acc_ns_r - tcq_pkg::NS_PER_SEC;
          acc_sec_nxt = acc_sec_r + 32'd1;
        end
      end
      tcq_pkg::ST_T_SLEW: acc_ns_nxt = acc_ns_r + {12'd0, slew_d_r};
      tcq_pkg::ST_T_CLK: begin
        clk_sec_nxt = acc_sec_r;
        clk_ns_nxt  = acc_ns_r[29:0];
        if (slew_rem_r != 32'd0) begin
          slew_rem_nxt = slew_rem_r - 32'd1;
          if (slew_rem_r == 32'd1) begin
            slew_d_nxt = 20'd0;
          end
        end
        done_nxt   = '0;
        n_nxt      = '0;
        pend_v_nxt = 1'b0;
        idx_nxt    = '0;
        found_nxt  = 1'b0;
      end
      tcq_pkg::ST_S_CMP: begin
        if (elig && better) begin
          found_nxt    = 1'b1;
          best_nxt     = idx_r;
          best_exp_nxt = exp_rd;
        end
        if (idx_r != AW'(SLOT_COUNT - 1)) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      tcq_pkg::ST_S_END: begin
        o_sec_nxt   = clk_sec_r;
        o_ns_nxt    = clk_ns_r;
        o_acc_nxt   = 1'b0;
        o_fired_nxt = pend_v_r;
        o_slot_nxt  = pend_v_r ? 4'(pend_r) : 4'd0;
        o_last_nxt  = !found_r;
      end
      tcq_pkg::ST_S_FIRE: begin
        done_nxt[best_r] = 1'b1;
        pend_nxt         = best_r;
        pend_v_nxt       = 1'b1;
        n_nxt            = n_r + tcq_pkg::CNT_W'(1);
        if (!per_r[best_r]) begin
          set_nxt[best_r] = 1'b0;
        end
      end
      tcq_pkg::ST_P_ADD: begin
        acc_sec_nxt = best_exp_r[61:30] + prd_rd[61:30];
        acc_ns_nxt  = {2'b00, best_exp_r[29:0]} + {2'b00, prd_rd[29:0]};
      end
      tcq_pkg::ST_S_NEXT: begin
        idx_nxt     = '0;
        found_nxt   = 1'b0;
        o_sec_nxt   = clk_sec_r;
        o_ns_nxt    = clk_ns_r;
        o_acc_nxt   = 1'b0;
        o_fired_nxt = 1'b1;
        o_slot_nxt  = 4'(pend_r);
        o_last_nxt  = 1'b1;
      end
      tcq_pkg::ST_A_REL: begin
        if (!abs_r) begin
          acc_sec_nxt = acc_sec_r + clk_sec_r;
          acc_ns_nxt  = acc_ns_r + {2'b00, clk_ns_r};
        end
      end
      tcq_pkg::ST_A_CHK: begin
        exp_nxt     = {acc_sec_r, acc_ns_r[29:0]};
        acc_sec_nxt = psec_r;
        acc_ns_nxt  = {2'b00, pns_r};
        o_acc_nxt   = 1'b0;
      end
      tcq_pkg::ST_A_WR: begin
        set_nxt[slot_addr] = 1'b1;
        per_nxt[slot_addr] = perf_r;
        o_acc_nxt          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tcq_pkg::ST_IDLE;
      ret_r      <= tcq_pkg::ST_IDLE;
      res_r      <= tcq_pkg::RES_RESET;
      clk_sec_r  <= '0;
      clk_ns_r   <= '0;
      slew_d_r   <= '0;
      slew_rem_r <= '0;
      set_r      <= '0;
      per_r      <= '0;
      done_r     <= '0;
      pend_v_r   <= 1'b0;
      found_r    <= 1'b0;
      n_r        <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      res_r      <= res_nxt;
      clk_sec_r  <= clk_sec_nxt;
      clk_ns_r   <= clk_ns_nxt;
      slew_d_r   <= slew_d_nxt;
      slew_rem_r <= slew_rem_nxt;
      set_r      <= set_nxt;
      per_r      <= per_nxt;
      done_r     <= done_nxt;
      pend_v_r   <= pend_v_nxt;
      found_r    <= found_nxt;
      n_r        <= n_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_sec_r  <= acc_sec_nxt;
    acc_ns_r   <= acc_ns_nxt;
    exp_r      <= exp_nxt;
    best_exp_r <= best_exp_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    slot_r     <= slot_nxt;
    abs_r      <= abs_nxt;
    perf_r     <= perf_nxt;
    psec_r     <= psec_nxt;
    pns_r      <= pns_nxt;
    o_sec_r    <= o_sec_nxt;
    o_ns_r     <= o_ns_nxt;
    o_fired_r  <= o_fired_nxt;
    o_slot_r   <= o_slot_nxt;
    o_acc_r    <= o_acc_nxt;
    o_last_r   <= o_last_nxt;
  end

  // outputs
  assign in_tready  = (state_r == tcq_pkg::ST_IDLE);
  assign out_tvalid = (state_r == tcq_pkg::ST_OUT);
  assign out_tdata  = {5'd0, o_acc_r, o_slot_r, o_ns_r, o_sec_r};
  assign out_tuser  = o_fired_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

// File: sv/tcq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tcq_ram #(
  parameter int W     = 62,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/tb_tick_clock_timer_queue.sv
// Testbench for tick_clock_timer_queue: a directed and random command stream,
// with a cycle-free predictor of the clock and timer slots, checked per result.
// Depends on tcq_pkg and the tick_clock_timer_queue RTL.
`default_nettype none
module tb_tick_clock_timer_queue;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] ws;
    logic [29:0] wn;
    logic        abs_t;
    logic        per;
    logic [31:0] ps;
    logic [29:0] pn;
    logic [19:0] sd;
    logic [31:0] st;
  } cmd_item_t;

  typedef struct {
    logic [31:0] s;
    logic [31:0] n;
  } stamp_t;

  typedef struct {
    logic [31:0] sec;
    logic [29:0] ns;
    logic        fired;
    logic [3:0]  slot;
    logic        acc;
    logic        last;
  } report_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser, out_tlast;
  logic [183:0] in_tdata;
  logic [1:0] in_tuser;
  logic [71:0] out_tdata;
  logic cfg_wr_en;
  logic [29:0] cfg_wr_data;

  tick_clock_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [29:0] res_ns;
  stamp_t      clk_now;
  logic [19:0] slew_delta;
  logic [31:0] slew_left;
  stamp_t      expiry [16];
  stamp_t      period [16];
  logic        slot_set [16];
  logic        slot_per [16];

  cmd_item_t pending_q[$];
  report_t   expected_q[$];
  cmd_item_t cur_item;
  int gap_left, burst_left;
  int mismatches = 0;
  bit failed = 0;
  bit hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic stamp_t carry_ns(logic [31:0] s, logic [63:0] n);
    stamp_t t;
    while (n >= 64'd1000000000) begin
      n = n - 64'd1000000000;
      s = s + 32'd1;
    end
    t.s = s;
    t.n = n[31:0];
    return t;
  endfunction

  function automatic stamp_t stamp_add(stamp_t a, stamp_t b);
    return carry_ns(a.s + b.s, 64'(a.n) + 64'(b.n));
  endfunction

  function automatic bit not_after(stamp_t a, stamp_t b);
    if (a.s != b.s) return a.s < b.s;
    return a.n <= b.n;
  endfunction

  task automatic push_report(logic f, logic [3:0] sl, logic a, logic l);
    report_t r;
    r.sec = clk_now.s;
    r.ns = clk_now.n[29:0];
    r.fired = f;
    r.slot = sl;
    r.acc = a;
    r.last = l;
    expected_q.push_back(r);
  endtask

  task automatic apply_command(cmd_item_t it);
    stamp_t w, e;
    bit done [16];
    int n, best;
    bit a;
    case (it.cmd)
      tcq_pkg::CMD_TICK: begin
        clk_now = carry_ns(clk_now.s, 64'(clk_now.n) + 64'(res_ns) + 64'(slew_delta));
        if (slew_left != 0) begin
          slew_left = slew_left - 1;
          if (slew_left == 0) slew_delta = 0;
        end
        foreach (done[i]) done[i] = 0;
        n = 0;
        while (n < tcq_pkg::MAX_RESULTS) begin
          best = -1;
          for (int i = 0; i < 16; i++) begin
            if (done[i] || !slot_set[i] || !not_after(expiry[i], clk_now)) continue;
            if (best < 0 || !not_after(expiry[best], expiry[i])) best = i;
          end
          if (best < 0) break;
          done[best] = 1;
          if (slot_per[best]) expiry[best] = stamp_add(expiry[best], period[best]);
          else slot_set[best] = 0;
          push_report(1'b1, best[3:0], 1'b0, 1'b0);
          n++;
        end
        if (n == 0) push_report(1'b0, 4'd0, 1'b0, 1'b1);
        else expected_q[$].last = 1'b1;
      end
      tcq_pkg::CMD_ARM: begin
        a = 0;
        w = carry_ns(it.ws, 64'(it.wn));
        e = it.abs_t ? w : stamp_add(clk_now, w);
        if (!not_after(e, clk_now)) begin
          expiry[it.slot] = e;
          period[it.slot] = carry_ns(it.ps, 64'(it.pn));
          slot_set[it.slot] = 1;
          slot_per[it.slot] = it.per;
          a = 1;
        end
        push_report(1'b0, 4'd0, a, 1'b1);
      end
      tcq_pkg::CMD_CANCEL: begin
        a = slot_set[it.slot];
        slot_set[it.slot] = 0;
        push_report(1'b0, 4'd0, a, 1'b1);
      end
      default: begin
        slew_delta = it.sd;
        slew_left = it.st;
        push_report(1'b0, 4'd0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      gap_left <= 0;
      burst_left <= 1;
    end else begin
      if (in_tvalid && in_tready) apply_command(cur_item);
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          in_tuser <= cur_item.cmd;
          in_tdata <= {2'b0, cur_item.st, cur_item.sd, cur_item.pn, cur_item.ps,
                       cur_item.per, cur_item.abs_t, cur_item.wn, cur_item.ws, cur_item.slot};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result tdata=%h", out_tdata);
        end else begin
          report_t r;
          r = expected_q.pop_front();
          if (out_tdata[31:0] !== r.sec || out_tdata[61:32] !== r.ns ||
              out_tuser !== r.fired || out_tdata[65:62] !== r.slot ||
              out_tdata[66] !== r.acc || out_tlast !== r.last ||
              out_tdata[71:67] !== 5'd0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp sec=%0d ns=%0d fired=%b slot=%0d acc=%b last=%b;",
                        " got sec=%0d ns=%0d fired=%b slot=%0d acc=%b last=%b"},
                       r.sec, r.ns, r.fired, r.slot, r.acc, r.last,
                       out_tdata[31:0], out_tdata[61:32], out_tuser, out_tdata[65:62],
                       out_tdata[66], out_tlast);
          end
        end
      end
      out_tready <= !hold_off && ($urandom_range(0, 99) < ((($time / 5000) % 2) ? 95 : 60));
    end
  end

  initial begin
    hold_off = 0;
    repeat (400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic cmd_item_t mk(logic [1:0] c, logic [3:0] sl, logic [31:0] ws,
                                   logic [29:0] wn, logic ab, logic pe,
                                   logic [31:0] ps, logic [29:0] pn);
    cmd_item_t it;
    it.cmd = c; it.slot = sl; it.ws = ws; it.wn = wn; it.abs_t = ab; it.per = pe;
    it.ps = ps; it.pn = pn; it.sd = 20'($urandom); it.st = $urandom;
    return it;
  endfunction

  function automatic cmd_item_t mk_rand(logic [1:0] c);
    return mk(c, 4'($urandom), $urandom, 30'($urandom), 1'($urandom), 1'($urandom),
              $urandom, 30'($urandom));
  endfunction

  function automatic cmd_item_t mk_slew(logic [19:0] d, logic [31:0] t);
    cmd_item_t it;
    it = mk_rand(tcq_pkg::CMD_SLEW);
    it.sd = d;
    it.st = t;
    return it;
  endfunction

  function automatic cmd_item_t rand_item(logic [29:0] res);
    cmd_item_t it;
    int k;
    k = $urandom_range(0, 99);
    it = mk_rand(tcq_pkg::CMD_TICK);
    if (k < 40) return it;
    if (k < 80) begin
      it.cmd = tcq_pkg::CMD_ARM;
      if ($urandom_range(0, 5) != 0) begin
        it.ws = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) : 0;
        it.wn = 30'($urandom_range(0, 6 * res));
        it.abs_t = $urandom_range(0, 4) == 0;
        it.ps = 0;
        it.pn = 30'($urandom_range(0, 4 * res));
      end
    end else if (k < 92) begin
      it.cmd = tcq_pkg::CMD_CANCEL;
    end else begin
      it.cmd = tcq_pkg::CMD_SLEW;
      if ($urandom_range(0, 2) != 0) it.st = $urandom_range(0, 20);
    end
    return it;
  endfunction

  task automatic write_resolution(logic [29:0] v);
    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    res_ns = v;
  endtask

  task automatic run_random(int count, logic [29:0] res);
    for (int i = 0; i < count; i++) pending_q.push_back(rand_item(res));
  endtask

  initial begin
    rst_n = 0;
    cfg_wr_en = 0; cfg_wr_data = '0;
    res_ns = tcq_pkg::RES_RESET;
    clk_now = '{0, 0}; slew_delta = 0; slew_left = 0;
    foreach (slot_set[i]) begin
      slot_set[i] = 0; slot_per[i] = 0;
      expiry[i] = '{0, 0}; period[i] = '{0, 0};
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default resolution
    pending_q.push_back(mk_slew(20'd500000, 32'd3));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 0, 0, 30'd15000000, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 1, 0, 30'd5000000, 0, 1, 0, 30'd20000000));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 2, 0, 0, 1, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 3, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 4, 32'hFFFFFFFF, 30'h3FFFFFFF, 1, 1,
                           32'hFFFFFFFF, 30'h3FFFFFFF));
    pending_q.push_back(mk(tcq_pkg::CMD_CANCEL, 4, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_CANCEL, 4, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 5, 0, 1, 0, 1, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 7, 0, 30'd12000000, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 6, 0, 30'd12000000, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_ARM, 0, 0, 30'd25000000, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++)
      pending_q.push_back(mk(tcq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_slew(20'hFFFFF, 32'd0));
    pending_q.push_back(mk(tcq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_CANCEL, 5, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_slew(20'd0, 32'd0));
    run_random(40, tcq_pkg::RES_RESET);

    write_resolution(30'h3FFFFFFF);
    run_random(30, 30'd400000000);
    write_resolution(30'd1);
    for (int i = 0; i < 16; i++)
      pending_q.push_back(mk(tcq_pkg::CMD_ARM, 4'(i), 0, 30'd1, 0, 0, 0, 0));
    pending_q.push_back(mk(tcq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    run_random(30, 30'd3);
    write_resolution(30'd999000000);
    run_random(30, 30'd999000000);
    write_resolution(30'd7000000);
    run_random(20, 30'd7000000);

    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
